/* rtl/vvfe_pkg.sv */
// ----------------------------------------------------------------------------
// vvfe_pkg
// Shared types and constants of the voxel visible-face extractor.
// ----------------------------------------------------------------------------
package vvfe_pkg;

   localparam int CHUNK_SIZE_DEF = 16;
   localparam int COORD_W        = 4;
   localparam int HEIGHT_W       = 5;
   localparam int DIR_W          = 3;
   localparam int VTX_W          = 17;
   localparam int FACE_VERTS     = 4;
   localparam int VTX_MAX        = 131068;  // largest multiple of 4 in 17 bits
   localparam int NUM_DIRS       = 6;
   localparam int QUEUE_DEPTH    = 2;

   // request type codes on the input channel
   localparam logic [1:0] REQ_FILL    = 2'd0;
   localparam logic [1:0] REQ_EXAMINE = 2'd1;
   localparam logic [1:0] REQ_CLEAR   = 2'd2;

   // face direction codes, in emission order
   localparam logic [DIR_W-1:0] DIR_UP      = 3'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN    = 3'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT    = 3'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT   = 3'd3;
   localparam logic [DIR_W-1:0] DIR_FORWARD = 3'd4;
   localparam logic [DIR_W-1:0] DIR_BACK    = 3'd5;

   typedef enum logic [1:0] {
      OP_FILL,
      OP_EXAMINE,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COORD_W-1:0]  z;
      logic [HEIGHT_W-1:0] height;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } push_type;

endpackage

/* rtl/voxel_visible_face_extractor.sv */
// ----------------------------------------------------------------------------
// voxel_visible_face_extractor
// Voxel chunk store with visible-face extraction for meshing.
// ----------------------------------------------------------------------------
// Requests pass a classifier and a two-entry queue into an executing back end
// that owns the column memory (one solid bit per voxel, one word per column)
// and the vertex counter. A column fill or a counter clear is done in the back
// end's idle state as it is taken. An examine reads the center column and its
// four side neighbors one after another through the single registered read
// port of the column memory, then forms the face mask, and faces then leave
// one per cycle while the result channel is ready. Requests that do nothing
// are taken and dropped at the front. Columns read as air after reset through
// per-column written flags, so there is no clearing pass.
// ----------------------------------------------------------------------------
module voxel_visible_face_extractor
   import vvfe_pkg::*;
#(
   parameter int CHUNK_SIZE = CHUNK_SIZE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [COORD_W-1:0]  req_col_x,
   input  logic [COORD_W-1:0]  req_col_y,
   input  logic [COORD_W-1:0]  req_voxel_z,
   input  logic [HEIGHT_W-1:0] req_column_height,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DIR_W-1:0]    rsp_face_direction,
   output logic [COORD_W-1:0]  rsp_face_x,
   output logic [COORD_W-1:0]  rsp_face_y,
   output logic [COORD_W-1:0]  rsp_face_z,
   output logic [VTX_W-1:0]    rsp_base_vertex,
   output logic                rsp_last_face
);

   push_type push;
   logic     queue_full;
   logic     cmd_valid;
   cmd_type  cmd;
   logic     cmd_ready;

   vvfe_front #(
      .CHUNK_SIZE (CHUNK_SIZE)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_col_x         (req_col_x),
      .req_col_y         (req_col_y),
      .req_voxel_z       (req_voxel_z),
      .req_column_height (req_column_height),
      .queue_full        (queue_full),
      .push              (push)
   );

   vvfe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (queue_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_ready (cmd_ready)
   );

   vvfe_back #(
      .CHUNK_SIZE (CHUNK_SIZE)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_ready          (cmd_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_face_direction (rsp_face_direction),
      .rsp_face_x         (rsp_face_x),
      .rsp_face_y         (rsp_face_y),
      .rsp_face_z         (rsp_face_z),
      .rsp_base_vertex    (rsp_base_vertex),
      .rsp_last_face      (rsp_last_face)
   );

endmodule

/* rtl/vvfe_front.sv */
// ----------------------------------------------------------------------------
// vvfe_front
// Accepts requests, drops the ones that do nothing and classifies the rest
// into commands for the queue.
// ----------------------------------------------------------------------------
module vvfe_front
   import vvfe_pkg::*;
#(
   parameter int CHUNK_SIZE = CHUNK_SIZE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic [COORD_W-1:0]  req_col_x,
   input  logic [COORD_W-1:0]  req_col_y,
   input  logic [COORD_W-1:0]  req_voxel_z,
   input  logic [HEIGHT_W-1:0] req_column_height,
   input  logic                queue_full,
   output push_type            push
);

   logic xy_ok;
   logic z_ok;
   logic h_ok;
   logic keep;
   op_type op;
   logic accepted_ff;

   assign xy_ok = (int'(req_col_x) < CHUNK_SIZE) && (int'(req_col_y) < CHUNK_SIZE);
   assign z_ok  = int'(req_voxel_z) < CHUNK_SIZE;
   assign h_ok  = int'(req_column_height) <= CHUNK_SIZE;

   always_comb begin
      keep = 1'b0;
      op   = OP_CLEAR;
      case (req_type)
         REQ_FILL: begin
            keep = xy_ok && h_ok;
            op   = OP_FILL;
         end
         REQ_EXAMINE: begin
            keep = xy_ok && z_ok;
            op   = OP_EXAMINE;
         end
         REQ_CLEAR: begin
            keep = 1'b1;
            op   = OP_CLEAR;
         end
         default: begin
            keep = 1'b0;
            op   = OP_CLEAR;
         end
      endcase
   end

   // keep ready low until accepted_ff is set after reset so the queue sees a clean start
   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= 1'b0;
      end else begin
         accepted_ff <= 1'b1;
      end
   end

   assign req_ready       = accepted_ff && !queue_full;
   assign push.valid      = req_valid && req_ready && keep;
   assign push.cmd.op     = op;
   assign push.cmd.x      = req_col_x;
   assign push.cmd.y      = req_col_y;
   assign push.cmd.z      = req_voxel_z;
   assign push.cmd.height = req_column_height;

endmodule

/* rtl/vvfe_queue.sv */
// ----------------------------------------------------------------------------
// vvfe_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module vvfe_queue
   import vvfe_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     full,
   output logic     cmd_valid,
   output cmd_type  cmd,
   input  logic     cmd_ready
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmd_type        slots_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  rd_ptr_ff;
   logic [CW-1:0]  count_ff;
   logic           do_push;
   logic           do_pop;

   assign full      = count_ff == CW'(QUEUE_DEPTH);
   assign cmd_valid = count_ff != '0;
   assign cmd       = slots_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = cmd_valid && cmd_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push.cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* rtl/vvfe_back.sv */
// ----------------------------------------------------------------------------
// vvfe_back
// Executes commands: owns the column memory and the vertex counter, reads
// the five columns around an examined voxel and emits its visible faces.
// ----------------------------------------------------------------------------
module vvfe_back
   import vvfe_pkg::*;
#(
   parameter int CHUNK_SIZE = CHUNK_SIZE_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DIR_W-1:0]    rsp_face_direction,
   output logic [COORD_W-1:0]  rsp_face_x,
   output logic [COORD_W-1:0]  rsp_face_y,
   output logic [COORD_W-1:0]  rsp_face_z,
   output logic [VTX_W-1:0]    rsp_base_vertex,
   output logic                rsp_last_face
);

   // only coordinates up to 15 reach the block, so columns past that stay air;
   // one bit above z = 15 is kept for the up neighbor of the top voxel when CHUNK_SIZE exceeds 16
   localparam int COORD_SPAN = 1 << COORD_W;
   localparam int DIM   = (CHUNK_SIZE < COORD_SPAN) ? CHUNK_SIZE : COORD_SPAN;
   localparam int ZW    = (CHUNK_SIZE < COORD_SPAN + 1) ? CHUNK_SIZE : COORD_SPAN + 1;
   localparam int DEPTH = DIM * DIM;
   localparam int AW    = $clog2(DEPTH);
   localparam int ZIW   = $clog2(ZW);
   localparam int NCOL  = 5;
   localparam int CW    = COORD_W + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_EMIT
   } state_type;

   state_type              state_ff;
   logic [2:0]             step_ff;
   logic [COORD_W-1:0]     x_ff;
   logic [COORD_W-1:0]     y_ff;
   logic [COORD_W-1:0]     z_ff;
   logic [ZW-1:0]          words_ff [NCOL];
   logic [NUM_DIRS-1:0]    mask_ff;
   logic [VTX_W-1:0]       count_ff;
   logic [VTX_W-1:0]       count_in;

   logic [ZW-1:0]          mem [DEPTH];
   logic [DEPTH-1:0]       written_ff;
   logic [ZW-1:0]          rd_data_ff;
   logic                   rd_written_ff;
   logic [ZW-1:0]          rd_word;

   logic                   mem_we;
   logic [AW-1:0]          wr_addr;
   logic [ZW-1:0]          fill_word;
   logic [AW-1:0]          rd_addr;

   logic [CW-1:0]          x5;
   logic [CW-1:0]          y5;
   logic [CW-1:0]          z5;
   logic                   left_ok;
   logic                   right_ok;
   logic                   fwd_ok;
   logic                   back_ok;
   logic                   up_ok;
   logic                   down_ok;
   logic [NUM_DIRS-1:0]    solid;
   logic                   center_solid;
   logic [NUM_DIRS-1:0]    vis_mask;

   logic                   emit_load;
   logic [DIR_W-1:0]       emit_dir;
   logic [NUM_DIRS-1:0]    mask_rest;

   function automatic logic [AW-1:0] col_addr(input logic [CW-1:0] cx,
                                              input logic [CW-1:0] cy);
      return AW'(int'(cy) * DIM + int'(cx));
   endfunction

   // -------------------------------------------------------------------------
   // column memory, entries read as air until first written
   // -------------------------------------------------------------------------
   assign mem_we  = (state_ff == S_IDLE) && cmd_valid && (cmd.op == OP_FILL);
   assign wr_addr = col_addr({1'b0, cmd.x}, {1'b0, cmd.y});

   always_comb begin
      for (int i = 0; i < ZW; i++) begin
         fill_word[i] = int'(cmd.height) > i;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= fill_word;
      end
      rd_data_ff    <= mem[rd_addr];
      rd_written_ff <= written_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (mem_we) begin
         written_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_word = rd_written_ff ? rd_data_ff : '0;

   // -------------------------------------------------------------------------
   // neighbor addressing: center, left, right, forward, back
   // -------------------------------------------------------------------------
   assign x5 = {1'b0, x_ff};
   assign y5 = {1'b0, y_ff};
   assign z5 = {1'b0, z_ff};

   assign left_ok  = y_ff != '0;
   assign right_ok = int'(y5) + 1 < DIM;
   assign fwd_ok   = int'(x5) + 1 < DIM;
   assign back_ok  = x_ff != '0;
   assign up_ok    = int'(z5) + 1 < CHUNK_SIZE;
   assign down_ok  = z_ff != '0;

   always_comb begin
      case (step_ff)
         3'd1:    rd_addr = col_addr(x5, y5 - 1'b1);
         3'd2:    rd_addr = col_addr(x5, y5 + 1'b1);
         3'd3:    rd_addr = col_addr(x5 + 1'b1, y5);
         3'd4:    rd_addr = col_addr(x5 - 1'b1, y5);
         default: rd_addr = col_addr(x5, y5);
      endcase
   end

   always_comb begin
      center_solid     = words_ff[0][ZIW'(z5)];
      solid[DIR_UP]      = up_ok    && words_ff[0][ZIW'(z5 + 1'b1)];
      solid[DIR_DOWN]    = down_ok  && words_ff[0][ZIW'(z5 - 1'b1)];
      solid[DIR_LEFT]    = left_ok  && words_ff[1][ZIW'(z5)];
      solid[DIR_RIGHT]   = right_ok && words_ff[2][ZIW'(z5)];
      solid[DIR_FORWARD] = fwd_ok   && words_ff[3][ZIW'(z5)];
      solid[DIR_BACK]    = back_ok  && words_ff[4][ZIW'(z5)];
      vis_mask = center_solid ? ~solid : '0;
   end

   // -------------------------------------------------------------------------
   // face emission: lowest pending direction first
   // -------------------------------------------------------------------------
   always_comb begin
      emit_dir = DIR_BACK;
      for (int d = NUM_DIRS - 1; d >= 0; d--) begin
         if (mask_ff[d]) begin
            emit_dir = DIR_W'(d);
         end
      end
      mask_rest = mask_ff & ~(NUM_DIRS'(1) << emit_dir);
   end

   assign emit_load = (state_ff == S_EMIT) && (!rsp_valid || rsp_ready);

   assign count_in = (count_ff >= VTX_W'(VTX_MAX - FACE_VERTS)) ? VTX_W'(VTX_MAX)
                                                              : count_ff + VTX_W'(FACE_VERTS);

   assign cmd_ready = state_ff == S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         step_ff   <= '0;
         count_ff  <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (emit_load) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  x_ff    <= cmd.x;
                  y_ff    <= cmd.y;
                  z_ff    <= cmd.z;
                  step_ff <= '0;
                  case (cmd.op)
                     OP_EXAMINE: state_ff <= S_READ;
                     OP_CLEAR:   count_ff <= '0;
                     default:    state_ff <= S_IDLE;
                  endcase
               end
            end
            S_READ: begin
               // word for step n-1 lands while step n is addressed
               if (step_ff != '0) begin
                  words_ff[step_ff - 1'b1] <= rd_word;
               end
               if (step_ff == 3'(NCOL)) begin
                  state_ff <= S_EVAL;
               end
               step_ff <= step_ff + 1'b1;
            end
            S_EVAL: begin
               mask_ff  <= vis_mask;
               state_ff <= (vis_mask != '0) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
               if (emit_load) begin
                  rsp_face_direction <= emit_dir;
                  rsp_face_x         <= x_ff;
                  rsp_face_y         <= y_ff;
                  rsp_face_z         <= z_ff;
                  rsp_base_vertex    <= count_ff;
                  rsp_last_face      <= mask_rest == '0;
                  count_ff           <= count_in;
                  mask_ff            <= mask_rest;
                  if (mask_rest == '0) begin
                     state_ff <= S_IDLE;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* test/voxel_visible_face_extractor_test.sv */
// ----------------------------------------------------------------------------
// voxel_visible_face_extractor_test
// Self-checking bench for the voxel visible-face extractor. A behavioral copy
// of the chunk and vertex counter predicts the face records of every accepted
// request. A short table of directed requests runs first, then a random mix
// of fills, examines, clears and unused requests follows. Both channels idle
// and stall at random, except while quiet is set.
// ----------------------------------------------------------------------------
module voxel_visible_face_extractor_test;
   import vvfe_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHUNK = CHUNK_SIZE_DEF;
   localparam logic [1:0] REQ_UNUSED = 2'd3;  // no operation
   localparam int RANDOM_REQUESTS = 190;

   typedef struct {
      logic [1:0]          kind;
      logic [COORD_W-1:0]  x;
      logic [COORD_W-1:0]  y;
      logic [COORD_W-1:0]  z;
      logic [HEIGHT_W-1:0] height;
   } voxel_req_type;

   typedef struct {
      logic [DIR_W-1:0]   dir;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [VTX_W-1:0]   base;
      logic               last;
   } face_type;

   // typed faces / first_base of -1 leave the row to the predictor alone
   typedef struct {
      voxel_req_type req;
      int            faces;
      int            first_base;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_type = '0;
   logic [COORD_W-1:0]  req_col_x = '0;
   logic [COORD_W-1:0]  req_col_y = '0;
   logic [COORD_W-1:0]  req_voxel_z = '0;
   logic [HEIGHT_W-1:0] req_column_height = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DIR_W-1:0]    rsp_face_direction;
   logic [COORD_W-1:0]  rsp_face_x;
   logic [COORD_W-1:0]  rsp_face_y;
   logic [COORD_W-1:0]  rsp_face_z;
   logic [VTX_W-1:0]    rsp_base_vertex;
   logic                rsp_last_face;

   // predicted chunk contents and vertex counter
   logic [CHUNK-1:0] column_bits [CHUNK*CHUNK];
   logic [VTX_W-1:0] vertex_base;
   face_type         pending_faces[$];

   int mismatch_count = 0;
   bit quiet = 1'b0;  // no idling on either side while set

   voxel_visible_face_extractor dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_col_x          (req_col_x),
      .req_col_y          (req_col_y),
      .req_voxel_z        (req_voxel_z),
      .req_column_height  (req_column_height),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_face_direction (rsp_face_direction),
      .rsp_face_x         (rsp_face_x),
      .rsp_face_y         (rsp_face_y),
      .rsp_face_z         (rsp_face_z),
      .rsp_base_vertex    (rsp_base_vertex),
      .rsp_last_face      (rsp_last_face)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("FAIL");
      $finish;
   end

   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch: %s", what);
      end
   endtask

   // outside the chunk counts as air
   function automatic bit voxel_solid(input int x, input int y, input int z);
      if (x < 0 || y < 0 || z < 0 || x >= CHUNK || y >= CHUNK || z >= CHUNK) begin
         return 1'b0;
      end
      return column_bits[y*CHUNK + x][z];
   endfunction

   // applies one request to the chunk copy, queues its faces, returns the count
   function automatic int predict_faces(input voxel_req_type r);
      logic [CHUNK-1:0] ones;
      logic [DIR_W-1:0] dir;
      face_type         f;
      int               n;
      int               nx;
      int               ny;
      int               nz;
      ones = '1;
      n = 0;
      case (r.kind)
         REQ_FILL: begin
            if (r.height <= CHUNK) begin
               column_bits[int'(r.y)*CHUNK + int'(r.x)] = ones >> (CHUNK - int'(r.height));
            end
         end
         REQ_CLEAR: begin
            vertex_base = '0;
         end
         REQ_EXAMINE: begin
            if (voxel_solid(int'(r.x), int'(r.y), int'(r.z))) begin
               for (int d = 0; d < NUM_DIRS; d++) begin
                  dir = DIR_W'(d);
                  nx = int'(r.x);
                  ny = int'(r.y);
                  nz = int'(r.z);
                  case (dir)
                     DIR_UP:      nz = nz + 1;
                     DIR_DOWN:    nz = nz - 1;
                     DIR_LEFT:    ny = ny - 1;
                     DIR_RIGHT:   ny = ny + 1;
                     DIR_FORWARD: nx = nx + 1;
                     default:     nx = nx - 1;
                  endcase
                  if (!voxel_solid(nx, ny, nz)) begin
                     f.dir = dir;
                     f.x = r.x;
                     f.y = r.y;
                     f.z = r.z;
                     f.base = vertex_base;
                     f.last = 1'b0;
                     pending_faces.push_back(f);
                     if (int'(vertex_base) >= VTX_MAX - FACE_VERTS) begin
                        vertex_base = VTX_W'(VTX_MAX);
                     end else begin
                        vertex_base = vertex_base + VTX_W'(FACE_VERTS);
                     end
                     n++;
                  end
               end
               if (n > 0) begin
                  pending_faces[pending_faces.size()-1].last = 1'b1;
               end
            end
         end
         default: ;
      endcase
      return n;
   endfunction

   function automatic voxel_req_type make_req(input logic [1:0] kind, input int x,
                                              input int y, input int z, input int h);
      voxel_req_type r;
      r.kind = kind;
      r.x = COORD_W'(x);
      r.y = COORD_W'(y);
      r.z = COORD_W'(z);
      r.height = HEIGHT_W'(h);
      return r;
   endfunction

   function automatic directed_row_type row(input logic [1:0] kind, input int x, input int y,
                                            input int z, input int h, input int faces,
                                            input int first_base);
      directed_row_type t;
      t.req = make_req(kind, x, y, z, h);
      t.faces = faces;
      t.first_base = first_base;
      return t;
   endfunction

   // mostly dense windows at two opposite corners and the center so examines hit solid voxels
   function automatic voxel_req_type random_req();
      voxel_req_type r;
      int pick;
      int corner;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r.kind = REQ_FILL;
      end else if (pick < 88) begin
         r.kind = REQ_EXAMINE;
      end else if (pick < 94) begin
         r.kind = REQ_CLEAR;
      end else begin
         r.kind = REQ_UNUSED;
      end
      if ($urandom_range(0, 3) == 0) begin
         r.x = COORD_W'($urandom_range(0, CHUNK - 1));
         r.y = COORD_W'($urandom_range(0, CHUNK - 1));
      end else begin
         corner = 6 * $urandom_range(0, 2);
         r.x = COORD_W'(corner + $urandom_range(0, 3));
         r.y = COORD_W'(corner + $urandom_range(0, 3));
      end
      r.z = COORD_W'($urandom_range(0, CHUNK - 1));
      if ($urandom_range(0, 9) == 0) begin
         r.height = HEIGHT_W'($urandom_range(CHUNK + 1, 31));
      end else begin
         r.height = HEIGHT_W'($urandom_range(0, CHUNK));
      end
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(input voxel_req_type r, output int faces,
                               output int first_base);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= r.kind;
      req_col_x <= r.x;
      req_col_y <= r.y;
      req_voxel_z <= r.z;
      req_column_height <= r.height;
      do @(posedge clock); while (!req_ready);
      first_base = int'(vertex_base);
      faces = predict_faces(r);
      @(negedge clock);
   endtask

   // result side: random stall before each face, then check against the oldest
   initial begin
      int       stall;
      face_type want;
      @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         if (pending_faces.size() == 0) begin
            log_mismatch($sformatf("unexpected face dir %0d at %0d,%0d,%0d base %0d",
               rsp_face_direction, rsp_face_x, rsp_face_y, rsp_face_z, rsp_base_vertex));
         end else begin
            want = pending_faces.pop_front();
            if (rsp_face_direction !== want.dir || rsp_face_x !== want.x ||
                rsp_face_y !== want.y || rsp_face_z !== want.z ||
                rsp_base_vertex !== want.base || rsp_last_face !== want.last) begin
               log_mismatch($sformatf({"face expected dir %0d xyz %0d,%0d,%0d base %0d ",
                  "last %0d, got dir %0d xyz %0d,%0d,%0d base %0d last %0d"},
                  want.dir, want.x, want.y, want.z, want.base, want.last,
                  rsp_face_direction, rsp_face_x, rsp_face_y, rsp_face_z,
                  rsp_base_vertex, rsp_last_face));
            end
         end
         @(negedge clock);
      end
   end

   initial begin
      directed_row_type plan[$];
      voxel_req_type    r;
      int               n;
      int               first;
      int               counted;

      for (int i = 0; i < CHUNK*CHUNK; i++) begin
         column_bits[i] = '0;
      end
      vertex_base = '0;

      // kind, x, y, z, height, typed face count, typed first base
      plan.push_back(row(REQ_EXAMINE,  0,  0,  0,  0, 0, -1));   // empty chunk
      plan.push_back(row(REQ_FILL,     0,  0,  0,  1, 0, -1));
      plan.push_back(row(REQ_EXAMINE,  0,  0,  0,  0, 6,  0));   // lone voxel at corner
      plan.push_back(row(REQ_EXAMINE,  0,  0,  1,  0, 0, -1));   // air above it
      plan.push_back(row(REQ_FILL,    15, 15,  0, 16, 0, -1));   // full column
      plan.push_back(row(REQ_EXAMINE, 15, 15, 15,  0, 5, 24));
      plan.push_back(row(REQ_EXAMINE, 15, 15,  0,  0, 5, 44));
      plan.push_back(row(REQ_FILL,    15, 15,  0, 17, 0, -1));   // height too large
      plan.push_back(row(REQ_EXAMINE, 15, 15,  8,  0, 4, 64));
      plan.push_back(row(REQ_FILL,    15, 15, 15, 31, 0, -1));   // height too large
      plan.push_back(row(REQ_FILL,    15, 14,  0, 16, 0, -1));
      plan.push_back(row(REQ_FILL,    14, 15,  0, 16, 0, -1));
      plan.push_back(row(REQ_EXAMINE, 15, 15,  8,  0, 2, 80));   // only chunk-edge faces
      plan.push_back(row(REQ_UNUSED,  15, 15, 15, 31, 0, -1));
      plan.push_back(row(REQ_CLEAR,    0,  0,  0,  0, 0, -1));
      plan.push_back(row(REQ_EXAMINE,  0,  0,  0,  0, 6,  0));   // counter back at zero
      plan.push_back(row(REQ_FILL,     0,  0,  0,  0, 0, -1));   // column back to air
      plan.push_back(row(REQ_EXAMINE,  0,  0,  0,  0, 0, -1));
      plan.push_back(row(REQ_FILL,     7,  8,  0, 16, 0, -1));
      plan.push_back(row(REQ_FILL,     6,  8,  0, 16, 0, -1));
      plan.push_back(row(REQ_FILL,     8,  8,  0, 16, 0, -1));
      plan.push_back(row(REQ_FILL,     7,  7,  0, 16, 0, -1));
      plan.push_back(row(REQ_FILL,     7,  9,  0, 16, 0, -1));
      plan.push_back(row(REQ_EXAMINE,  7,  8,  7,  0, 0, -1));   // fully enclosed
      plan.push_back(row(REQ_EXAMINE,  8,  8,  0,  0, -1, -1));

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         send_request(plan[i].req, n, first);
         if (plan[i].faces >= 0 && (n != plan[i].faces ||
             (n > 0 && plan[i].first_base >= 0 && first != plan[i].first_base))) begin
            log_mismatch($sformatf({"row %0d predicts %0d faces from base %0d, ",
               "table has %0d from %0d"},
               i, n, first, plan[i].faces, plan[i].first_base));
         end
      end

      counted = 0;
      while (counted < RANDOM_REQUESTS) begin
         quiet = (counted >= 90 && counted < 130);
         r = random_req();
         send_request(r, n, first);
         if (!(r.kind == REQ_UNUSED || (r.kind == REQ_FILL && r.height > CHUNK))) begin
            counted++;
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (pending_faces.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/vvfe_pkg.sv
rtl/vvfe_front.sv
rtl/vvfe_queue.sv
rtl/vvfe_back.sv
rtl/voxel_visible_face_extractor.sv
test/voxel_visible_face_extractor_test.sv
